FILE: design/amq_pkg.sv
// ----------------------------------------------------------------------------
// amq_pkg: shared types and constants for the alpha mask quad extruder
// Field widths, face codes and the job word passed from the front end to the
// quad sequencer.
// ----------------------------------------------------------------------------
package amq_pkg;

  localparam int DIM_W  = 9;
  localparam int VTX_W  = 18;
  localparam int BASE_W = VTX_W - 1;
  localparam int FACE_N = 6;

  localparam logic [DIM_W-1:0] RST_WIDTH  = 9'd16;
  localparam logic [DIM_W-1:0] RST_HEIGHT = 9'd16;

  localparam logic CFG_IDX_WIDTH  = 1'b0;
  localparam logic CFG_IDX_HEIGHT = 1'b1;

  typedef enum logic [2:0] {
    FACE_FRONT  = 3'd0,
    FACE_BACK   = 3'd1,
    FACE_LEFT   = 3'd2,
    FACE_RIGHT  = 3'd3,
    FACE_BOTTOM = 3'd4,
    FACE_TOP    = 3'd5
  } face_kind_t;

  typedef struct packed {
    logic [FACE_N-1:0] mask;
    logic [BASE_W-1:0] lo;
    logic [BASE_W-1:0] hi;
  } amq_job_t;

endpackage

FILE: design/alpha_mask_extrude_quads.sv
// ----------------------------------------------------------------------------
// alpha_mask_extrude_quads: sprite alpha mask to extruded quad indices
// Input stream: one word per texel, bottom row first, in raster order;
// in_tuser is the flush flag, in_tdata the alpha. After the last row send one
// row of flush words to drain it. Output stream: one word per quad, four grid
// vertex indices in out_tdata, face code in out_tuser, out_tlast on the last
// quad that an input word causes. Width and height sit on the APB port and
// are to be written by the user only while the block is idle (unchecked). A
// word that yields no quad does not stall the input. A texel that yields n
// quads (2 to 6) holds the input while its quads are walked: the single
// output register takes one quad per cycle while the receiver is ready.
// Line banks are read at accept; the data reaches the judge stage in the
// cycle after. Reset: both line banks are swept to zero, one entry per
// cycle, with in_tready low; configuration writes work throughout. A
// stalled receiver holds the output register; the input stalls as soon as
// the quad sequencer and judge stage are full.
// ----------------------------------------------------------------------------
module alpha_mask_extrude_quads
  import amq_pkg::*;
#(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,    // [7:0] alpha
  input  logic        in_tuser,    // [0] command (1 = flush)
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [71:0] out_tdata,   // [17:0] corner_a, [35:18] corner_b,
                                   // [53:36] corner_c, [71:54] corner_d
  output logic [2:0]  out_tuser,   // [2:0] face_kind
  output logic        out_tlast,   // last_quad
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  logic [DIM_W-1:0] width_r, width_nxt;
  logic [DIM_W-1:0] height_r, height_nxt;
  logic [DIM_W-1:0] w, h;
  logic             cfg_wr;

  logic             job_valid, job_ready;
  amq_job_t         job;
  logic             clr_busy;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_prdata = (cfg_paddr[2] == CFG_IDX_HEIGHT) ? 32'(height_r) : 32'(width_r);

  always_comb begin
    width_nxt  = width_r;
    height_nxt = height_r;
    if (cfg_wr) begin
      unique case (cfg_paddr[2])
        CFG_IDX_WIDTH:  width_nxt  = cfg_pwdata[DIM_W-1:0];
        CFG_IDX_HEIGHT: height_nxt = cfg_pwdata[DIM_W-1:0];
        default:        width_nxt  = width_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= RST_WIDTH;
      height_r <= RST_HEIGHT;
    end else begin
      width_r  <= width_nxt;
      height_r <= height_nxt;
    end
  end

  assign w = (width_r == '0) ? 9'd1 :
             (32'(width_r) > MAX_WIDTH) ? DIM_W'(MAX_WIDTH) : width_r;
  assign h = (height_r == '0) ? 9'd1 :
             (32'(height_r) > MAX_HEIGHT) ? DIM_W'(MAX_HEIGHT) : height_r;

  amq_front #(.MAX_WIDTH(MAX_WIDTH)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .flush     (in_tuser),
    .alpha     (in_tdata),
    .w         (w),
    .h         (h),
    .job_valid (job_valid),
    .job_ready (job_ready),
    .job       (job),
    .clr_busy  (clr_busy)
  );

  amq_emit u_emit (
    .clk       (clk),
    .rst_n     (rst_n),
    .job_valid (job_valid),
    .job_ready (job_ready),
    .job       (job),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_kind  (out_tuser),
    .out_a     (out_tdata[17:0]),
    .out_b     (out_tdata[35:18]),
    .out_c     (out_tdata[53:36]),
    .out_d     (out_tdata[71:54]),
    .out_last  (out_tlast)
  );

  // hold input during bank sweep
  a_no_accept_clear: assert property (@(posedge clk) disable iff (!rst_n)
    clr_busy |-> !in_tready)
    else $error("input taken during line bank sweep");

  // every judged opaque texel carries front and back faces
  a_job_front_back: assert property (@(posedge clk) disable iff (!rst_n)
    job_valid |-> (job.mask[FACE_FRONT] && job.mask[FACE_BACK]))
    else $error("job without front/back face");

  // front quad second corner is one column right of the first
  a_front_step: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && (out_tuser == FACE_FRONT)) |->
      (out_tdata[35:18] == out_tdata[17:0] + 18'd2))
    else $error("front quad corner mismatch");

  // first quad of a word reaches the output after a new job is taken
  a_emit_after_job: assert property (@(posedge clk) disable iff (!rst_n)
    (job_valid && job_ready) |=> ##1 out_tvalid)
    else $error("job taken but no quad presented");

endmodule

FILE: design/amq_ram.sv
// ----------------------------------------------------------------------------
// amq_ram: generic synchronous RAM
// One write port, two read ports, registered read data, read-first.
// ----------------------------------------------------------------------------
module amq_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_a,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
    end
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

endmodule

FILE: design/amq_front.sv
// ----------------------------------------------------------------------------
// amq_front: line store front end
// Tracks column and row, reads and writes the two opaque line banks, clears
// them after reset and classifies each judged texel into a face mask.
// ----------------------------------------------------------------------------
module amq_front
  import amq_pkg::*;
#(
  parameter int MAX_WIDTH = 256
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic             flush,
  input  logic [7:0]       alpha,
  input  logic [DIM_W-1:0] w,
  input  logic [DIM_W-1:0] h,
  output logic             job_valid,
  input  logic             job_ready,
  output amq_job_t         job,
  output logic             clr_busy
);

  localparam int AW = $clog2(MAX_WIDTH);

  logic [DIM_W-1:0] col_r, col_nxt;
  logic [DIM_W-1:0] row_r, row_nxt;
  logic             sel_r, sel_nxt;
  logic             clr_busy_r, clr_busy_nxt;
  logic [AW-1:0]    clr_cnt_r, clr_cnt_nxt;

  logic             s1_valid_r, s1_valid_nxt;
  logic             s1_sel_r;
  logic [DIM_W-1:0] s1_x_r;
  logic [DIM_W-1:0] s1_row_r;
  logic             s1_above_r;
  logic             prev_r, prev_nxt;

  logic             fire, ignore, take, above, last_col;
  logic [DIM_W:0]   xp1;
  logic             s1_adv;

  logic             b0_we, b1_we;
  logic [AW-1:0]    waddr;
  logic             wdata;
  logic             b0_a, b0_b, b1_a, b1_b;

  logic             n_cur, n_next, o_cur, active;
  logic [DIM_W-1:0] y;
  logic [DIM_W:0]   wp1, s1_xp1;
  logic [DIM_W+10:0] lo_sum, hi_sum;
  logic             left, right, bottom, top;

  // accept side
  assign fire     = in_valid && in_ready;
  assign ignore   = (row_r > h) || ((row_r == h) && !flush);
  assign take     = fire && !ignore;
  assign above    = !flush && (row_r < h) && (alpha != 8'd0);
  assign xp1      = {1'b0, col_r} + 10'd1;
  assign last_col = xp1 >= {1'b0, w};
  assign in_ready = !clr_busy_r && (!s1_valid_r || s1_adv);
  assign clr_busy = clr_busy_r;

  assign b0_we = clr_busy_r || (take && sel_r);
  assign b1_we = clr_busy_r || (take && !sel_r);
  assign waddr = clr_busy_r ? clr_cnt_r : AW'(col_r);
  assign wdata = clr_busy_r ? 1'b0 : above;

  amq_ram #(.WIDTH(1), .DEPTH(MAX_WIDTH)) u_bank0 (
    .clk     (clk),
    .we      (b0_we),
    .waddr   (waddr),
    .wdata   (wdata),
    .re      (take),
    .raddr_a (AW'(col_r)),
    .raddr_b (AW'(xp1)),
    .rdata_a (b0_a),
    .rdata_b (b0_b)
  );

  amq_ram #(.WIDTH(1), .DEPTH(MAX_WIDTH)) u_bank1 (
    .clk     (clk),
    .we      (b1_we),
    .waddr   (waddr),
    .wdata   (wdata),
    .re      (take),
    .raddr_a (AW'(col_r)),
    .raddr_b (AW'(xp1)),
    .rdata_a (b1_a),
    .rdata_b (b1_b)
  );

  always_comb begin
    col_nxt      = col_r;
    row_nxt      = row_r;
    sel_nxt      = sel_r;
    clr_busy_nxt = clr_busy_r;
    clr_cnt_nxt  = clr_cnt_r;
    if (clr_busy_r) begin
      clr_cnt_nxt = clr_cnt_r + 1'b1;
      if (clr_cnt_r == AW'(MAX_WIDTH - 1)) begin
        clr_busy_nxt = 1'b0;
      end
    end
    if (take) begin
      if (last_col) begin
        col_nxt = '0;
        row_nxt = row_r + 9'd1;
        sel_nxt = !sel_r;
      end else begin
        col_nxt = xp1[DIM_W-1:0];
      end
    end
  end

  // judge stage: line bank data valid here
  assign n_cur  = s1_sel_r ? b1_a : b0_a;
  assign n_next = s1_sel_r ? b1_b : b0_b;
  assign o_cur  = s1_sel_r ? b0_a : b1_a;
  assign active = (s1_row_r != '0) && n_cur;
  assign y      = s1_row_r - 9'd1;
  assign wp1    = {1'b0, w} + 10'd1;
  assign s1_xp1 = {1'b0, s1_x_r} + 10'd1;

  assign left   = (s1_x_r == '0) || !prev_r;
  assign right  = (s1_xp1 >= {1'b0, w}) || !n_next;
  assign bottom = (y == '0) || !o_cur;
  assign top    = !s1_above_r;

  assign lo_sum = 20'(y) * 20'(wp1) + 20'(s1_x_r);
  assign hi_sum = 20'(s1_row_r) * 20'(wp1) + 20'(s1_x_r);

  assign job_valid = s1_valid_r && active;
  assign job.mask  = {top, bottom, right, left, 1'b1, 1'b1};
  assign job.lo    = lo_sum[BASE_W-1:0];
  assign job.hi    = hi_sum[BASE_W-1:0];

  assign s1_adv = s1_valid_r && (!active || job_ready);

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    prev_nxt     = prev_r;
    if (s1_adv) begin
      s1_valid_nxt = 1'b0;
      prev_nxt     = n_cur;
    end
    if (take) begin
      s1_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r      <= '0;
      row_r      <= '0;
      sel_r      <= 1'b0;
      clr_busy_r <= 1'b1;
      clr_cnt_r  <= '0;
      s1_valid_r <= 1'b0;
      prev_r     <= 1'b0;
    end else begin
      col_r      <= col_nxt;
      row_r      <= row_nxt;
      sel_r      <= sel_nxt;
      clr_busy_r <= clr_busy_nxt;
      clr_cnt_r  <= clr_cnt_nxt;
      s1_valid_r <= s1_valid_nxt;
      prev_r     <= prev_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      s1_sel_r   <= sel_r;
      s1_x_r     <= col_r;
      s1_row_r   <= row_r;
      s1_above_r <= above;
    end
  end

endmodule

FILE: design/amq_emit.sv
// ----------------------------------------------------------------------------
// amq_emit: quad sequencer
// Walks the face mask of one judged texel, one quad per cycle while the
// receiver is ready, into the output register.
// ----------------------------------------------------------------------------
module amq_emit
  import amq_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             job_valid,
  output logic             job_ready,
  input  amq_job_t         job,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [2:0]       out_kind,
  output logic [VTX_W-1:0] out_a,
  output logic [VTX_W-1:0] out_b,
  output logic [VTX_W-1:0] out_c,
  output logic [VTX_W-1:0] out_d,
  output logic             out_last
);

  logic [FACE_N-1:0] mask_r, mask_nxt;
  logic [BASE_W-1:0] lo_r, hi_r;
  logic              out_valid_r, out_valid_nxt;
  logic [2:0]        kind_r;
  logic [VTX_W-1:0]  a_r, b_r, c_r, d_r;
  logic              last_r;

  logic [2:0]        pick;
  face_kind_t        face;
  logic [FACE_N-1:0] rest;
  logic              load_out, take_job;
  logic [BASE_W-1:0] lo1, hi1;
  logic [VTX_W-1:0]  a_n, b_n, c_n, d_n;

  function automatic logic [2:0] first_set(logic [FACE_N-1:0] m);
    logic [2:0] idx;
    idx = 3'd0;
    for (int i = FACE_N - 1; i >= 0; i--) begin
      if (m[i]) idx = 3'(i);
    end
    return idx;
  endfunction

  assign pick      = first_set(mask_r);
  assign face      = face_kind_t'(pick);
  assign rest      = mask_r & ~(6'b000001 << pick);
  assign load_out  = (mask_r != '0) && (!out_valid_r || out_ready);
  assign job_ready = (mask_r == '0) || (load_out && (rest == '0));
  assign take_job  = job_valid && job_ready;

  assign lo1 = lo_r + 17'd1;
  assign hi1 = hi_r + 17'd1;

  always_comb begin
    unique case (face)
      FACE_FRONT: begin
        a_n = {lo_r, 1'b0}; b_n = {lo1, 1'b0}; c_n = {hi1, 1'b0}; d_n = {hi_r, 1'b0};
      end
      FACE_BACK: begin
        a_n = {lo_r, 1'b1}; b_n = {hi_r, 1'b1}; c_n = {hi1, 1'b1}; d_n = {lo1, 1'b1};
      end
      FACE_LEFT: begin
        a_n = {lo_r, 1'b0}; b_n = {hi_r, 1'b0}; c_n = {hi_r, 1'b1}; d_n = {lo_r, 1'b1};
      end
      FACE_RIGHT: begin
        a_n = {lo1, 1'b0}; b_n = {lo1, 1'b1}; c_n = {hi1, 1'b1}; d_n = {hi1, 1'b0};
      end
      FACE_BOTTOM: begin
        a_n = {lo_r, 1'b0}; b_n = {lo_r, 1'b1}; c_n = {lo1, 1'b1}; d_n = {lo1, 1'b0};
      end
      FACE_TOP: begin
        a_n = {hi_r, 1'b0}; b_n = {hi1, 1'b0}; c_n = {hi1, 1'b1}; d_n = {hi_r, 1'b1};
      end
      default: begin
        a_n = '0; b_n = '0; c_n = '0; d_n = '0;
      end
    endcase
  end

  always_comb begin
    mask_nxt = mask_r;
    if (load_out) begin
      mask_nxt = rest;
    end
    if (take_job) begin
      mask_nxt = job.mask;
    end
    out_valid_nxt = out_valid_r;
    if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (load_out) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      mask_r      <= mask_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take_job) begin
      lo_r <= job.lo;
      hi_r <= job.hi;
    end
    if (load_out) begin
      kind_r <= pick;
      a_r    <= a_n;
      b_r    <= b_n;
      c_r    <= c_n;
      d_r    <= d_n;
      last_r <= (rest == '0);
    end
  end

  assign out_valid = out_valid_r;
  assign out_kind  = kind_r;
  assign out_a     = a_r;
  assign out_b     = b_r;
  assign out_c     = c_r;
  assign out_d     = d_r;
  assign out_last  = last_r;

endmodule
